/* rtl/rra_pkg.sv */
package rra_pkg;

  // Bitmap geometry
  localparam int MAX_PARTITIONS = 1024;
  localparam int WORD_BITS      = 64;
  localparam int MAP_WORDS      = MAX_PARTITIONS / WORD_BITS;
  localparam int PART_W         = $clog2(MAX_PARTITIONS);
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int ADDR_W         = $clog2(MAP_WORDS);
  localparam int THR_W          = 11;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PART_W-1:0]    part_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bitidx_t;
  typedef logic [THR_W-1:0]     thr_t;

  localparam word_t WORD_ONES = '1;
  localparam word_t WORD_ONE  = word_t'(1);

  // Item opcodes
  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Bitmap memory request from the sequencer
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  clr_all;
  } mem_req_t;

  // Index of the highest set bit
  function automatic bitidx_t top_set(word_t x);
    bitidx_t idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (x[i]) idx = bitidx_t'(i);
    end
    return idx;
  endfunction

  // Index of the lowest set bit
  function automatic bitidx_t bottom_set(word_t x);
    bitidx_t idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) idx = bitidx_t'(i);
    end
    return idx;
  endfunction

  // Bits of word w that fall inside partitions pf..pl
  function automatic word_t span_mask(addr_t w, part_t pf, part_t pl);
    word_t   lo_m;
    word_t   hi_m;
    addr_t   wf;
    addr_t   wl;
    bitidx_t bf;
    bitidx_t bl;
    wf = pf[PART_W-1:BIT_W];
    bf = pf[BIT_W-1:0];
    wl = pl[PART_W-1:BIT_W];
    bl = pl[BIT_W-1:0];
    if (w < wf)       lo_m = '0;
    else if (w == wf) lo_m = WORD_ONES << bf;
    else              lo_m = WORD_ONES;
    if (w > wl)       hi_m = '0;
    else if (w == wl) hi_m = WORD_ONES >> (bitidx_t'(WORD_BITS - 1) - bl);
    else              hi_m = WORD_ONES;
    return lo_m & hi_m;
  endfunction

endpackage

/* rtl/rra_ram.sv */
module rra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rra_seq.sv */
module rra_seq import rra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  logic     in_opcode,
  input  part_t    in_range_first,
  input  part_t    in_range_last,
  input  thr_t     threshold,
  input  word_t    rd_word,
  output mem_req_t mem_req,
  output logic     out_valid,
  output logic     out_released,
  output part_t    out_release_first,
  output part_t    out_release_last
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_LSCAN = 7'b0000100,
    ST_RSCAN = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_WPASS = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   op_r, op_nxt;
  logic   bad_r, bad_nxt;
  logic   rel_r, rel_nxt;
  part_t  first_r, first_nxt;
  part_t  last_r, last_nxt;
  part_t  lo_r, lo_nxt;
  part_t  hi_r, hi_nxt;
  addr_t  cur_r, cur_nxt;
  addr_t  end_r, end_nxt;

  part_t  last_sat;
  addr_t  wf, wl;
  word_t  cur_word;
  word_t  below, above;
  word_t  zl, zr;
  logic   l_stop, r_stop;
  logic [PART_W:0] lo_sum, hi_sum;
  part_t  lo_calc, hi_calc;
  thr_t   run_len;
  logic   rel_calc;
  word_t  wb_word;

  assign wf = first_r[PART_W-1:BIT_W];
  assign wl = last_r[PART_W-1:BIT_W];

  // Clamp the last partition to the bitmap size
  assign last_sat = ({1'b0, in_range_last} >= thr_t'(MAX_PARTITIONS)) ?
                    part_t'(MAX_PARTITIONS - 1) : in_range_last;

  // Current word with the new range already merged in
  assign cur_word = rd_word | span_mask(cur_r, first_r, last_r);

  // Left scan: highest clear bit below the run start
  assign below  = (cur_r == wf) ? ((WORD_ONE << first_r[BIT_W-1:0]) - WORD_ONE) : WORD_ONES;
  assign zl     = ~cur_word & below;
  assign l_stop = (zl != '0) || (cur_r == '0);
  assign lo_sum = {1'b0, cur_r, {BIT_W{1'b0}}} + (PART_W+1)'(top_set(zl)) + (PART_W+1)'(1);
  assign lo_calc = (zl == '0) ? {cur_r, {BIT_W{1'b0}}} : lo_sum[PART_W-1:0];

  // Right scan: lowest clear bit above the run end
  assign above  = (cur_r == wl) ?
                  ~(((WORD_ONE << last_r[BIT_W-1:0]) << 1) - WORD_ONE) : WORD_ONES;
  assign zr     = ~cur_word & above;
  assign r_stop = (zr != '0) || (cur_r == addr_t'(MAP_WORDS - 1));
  assign hi_sum = {1'b0, cur_r, {BIT_W{1'b0}}} + (PART_W+1)'(bottom_set(zr)) - (PART_W+1)'(1);
  assign hi_calc = (zr == '0) ? {cur_r, {BIT_W{1'b1}}} : hi_sum[PART_W-1:0];

  // Run length against threshold
  assign run_len  = {1'b0, hi_r} - {1'b0, lo_r} + thr_t'(1);
  assign rel_calc = run_len >= threshold;

  // Write-back word: clear the run if released, else merge the range
  assign wb_word = rel_r ? (rd_word & ~span_mask(cur_r, lo_r, hi_r))
                         : (rd_word | span_mask(cur_r, first_r, last_r));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    bad_nxt   = bad_r;
    rel_nxt   = rel_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    mem_req         = '0;
    mem_req.rd_addr = cur_r;
    mem_req.wr_addr = cur_r;
    mem_req.wr_data = wb_word;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          first_nxt = in_range_first;
          last_nxt  = last_sat;
          bad_nxt   = (in_range_first > in_range_last) ||
                      ({1'b0, in_range_first} >= thr_t'(MAX_PARTITIONS));
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rel_nxt = 1'b0;
        if (op_r == OP_CLEAR) begin
          mem_req.clr_all = 1'b1;
          state_nxt       = ST_OUT;
        end else if (bad_r) begin
          state_nxt = ST_OUT;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = wf;
          cur_nxt         = wf;
          state_nxt       = ST_LSCAN;
        end
      end
      ST_LSCAN: begin
        mem_req.rd_en = 1'b1;
        if (!l_stop) begin
          mem_req.rd_addr = cur_r - addr_t'(1);
          cur_nxt         = cur_r - addr_t'(1);
        end else begin
          lo_nxt          = lo_calc;
          mem_req.rd_addr = wl;
          cur_nxt         = wl;
          state_nxt       = ST_RSCAN;
        end
      end
      ST_RSCAN: begin
        if (!r_stop) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cur_r + addr_t'(1);
          cur_nxt         = cur_r + addr_t'(1);
        end else begin
          hi_nxt    = hi_calc;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rel_nxt = rel_calc;
        if (rel_calc) begin
          cur_nxt = lo_r[PART_W-1:BIT_W];
          end_nxt = hi_r[PART_W-1:BIT_W];
        end else begin
          cur_nxt = wf;
          end_nxt = wl;
        end
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cur_nxt;
        state_nxt       = ST_WPASS;
      end
      ST_WPASS: begin
        mem_req.wr_en = 1'b1;
        if (cur_r == end_r) begin
          state_nxt = ST_OUT;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cur_r + addr_t'(1);
          cur_nxt         = cur_r + addr_t'(1);
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rel_r   <= rel_nxt;
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    bad_r   <= bad_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_released      = rel_r;
  assign out_release_first = rel_r ? lo_r : '0;
  assign out_release_last  = rel_r ? hi_r : '0;

`ifndef ASSERT_OFF
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("read and write to the same bitmap word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_zero_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_released) |->
      (out_release_first == '0 && out_release_last == '0))
    else $error("nonzero run bounds without release");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_released) |-> (out_release_first <= out_release_last))
    else $error("released run bounds reversed");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CHECK))
    else $error("accepted item not checked");
`endif

endmodule

/* rtl/ready_range_aggregator.sv */
// Channel   Ports                                   Transfer
// input     in_opcode, in_range_first/last          start && !busy
// result    out_released, out_release_first/last    out_valid (one cycle)
// config    cfg_wr_data (release_threshold)         cfg_wr_en
//
// A clear item or an ignored range goes from ST_CHECK straight to the result state ST_OUT.
// A mark item walks bitmap words left (ST_LSCAN) and right (ST_RSCAN), then
// rewrites the words of the run or range (ST_WPASS) before its result; the
// single read port of the bitmap memory sets the pace of each walk.
// busy stays high until the cycle after the result strobe.
// Synchronous active-low reset empties the bitmap at once through per-word
// valid bits and sets release_threshold to 1. Results cannot be stalled.
module ready_range_aggregator import rra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  logic  in_opcode,
  input  part_t in_range_first,
  input  part_t in_range_last,
  output logic  out_valid,
  output logic  out_released,
  output part_t out_release_first,
  output part_t out_release_last,
  input  logic  cfg_wr_en,
  input  thr_t  cfg_wr_data
);

  thr_t                 thr_r;
  logic [MAP_WORDS-1:0] valid_r, valid_nxt;
  addr_t                rd_addr_q_r;
  mem_req_t             mem_req;
  word_t                ram_rdata;
  word_t                rd_word;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= thr_t'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Per-word valid bits: an unwritten word reads as empty
  always_comb begin
    valid_nxt = valid_r;
    if (mem_req.clr_all) begin
      valid_nxt = '0;
    end else if (mem_req.wr_en) begin
      valid_nxt[mem_req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Address of the word now on the read port
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_addr_q_r <= mem_req.rd_addr;
    end
  end

  assign rd_word = valid_r[rd_addr_q_r] ? ram_rdata : '0;

  rra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (ram_rdata)
  );

  rra_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_range_first    (in_range_first),
    .in_range_last     (in_range_last),
    .threshold         (thr_r),
    .rd_word           (rd_word),
    .mem_req           (mem_req),
    .out_valid         (out_valid),
    .out_released      (out_released),
    .out_release_first (out_release_first),
    .out_release_last  (out_release_last)
  );

endmodule

/* tb/ready_range_aggregator_tb.sv */
module ready_range_aggregator_tb;
  import rra_pkg::*;

  typedef struct packed {
    logic  opcode;
    part_t first;
    part_t last;
  } ready_item_t;

  typedef struct packed {
    logic  released;
    part_t first;
    part_t last;
  } release_t;

  // DUT signals; the inputs are known from time zero
  logic  clk               = 1'b0;
  logic  rst_n             = 1'b0;
  logic  start             = 1'b0;
  logic  busy;
  logic  in_opcode         = OP_MARK;
  part_t in_range_first    = '0;
  part_t in_range_last     = '0;
  logic  out_valid;
  logic  out_released;
  part_t out_release_first;
  part_t out_release_last;
  logic  cfg_wr_en         = 1'b0;
  thr_t  cfg_wr_data       = thr_t'(1);

  // Shadow state of the block
  bit [MAX_PARTITIONS-1:0] pending_bits = '0;
  thr_t                    rel_threshold = thr_t'(1);

  ready_item_t ready_q[$];
  release_t    expected_release_q[$];
  ready_item_t cur_item;
  int          item_total    = 0;
  int          accepted_cnt  = 0;
  int          err_cnt       = 0;
  int          send_idle_pct = 0;
  int          hot_base      = 0;

  ready_range_aggregator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_range_first    (in_range_first),
    .in_range_last     (in_range_last),
    .out_valid         (out_valid),
    .out_released      (out_released),
    .out_release_first (out_release_first),
    .out_release_last  (out_release_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Clear empties the bitmap; else mark the range, grow it to the full pending run, release it if long enough
  function automatic release_t predict_release(ready_item_t it);
    release_t r;
    int       lo;
    int       hi;
    r = '0;
    if (it.opcode == OP_CLEAR) begin
      pending_bits = '0;
      return r;
    end
    if (it.first > it.last) return r;
    for (int p = it.first; p <= it.last; p++) pending_bits[p] = 1'b1;
    lo = it.first;
    while (lo > 0 && pending_bits[lo-1]) lo--;
    hi = it.last;
    while (hi < MAX_PARTITIONS - 1 && pending_bits[hi+1]) hi++;
    if (hi - lo + 1 >= int'(rel_threshold)) begin
      for (int p = lo; p <= hi; p++) pending_bits[p] = 1'b0;
      r.released = 1'b1;
      r.first    = part_t'(lo);
      r.last     = part_t'(hi);
    end
    return r;
  endfunction

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  task automatic push_item(logic op, int first, int last);
    ready_item_t it;
    it.opcode = op;
    it.first  = part_t'(first);
    it.last   = part_t'(last);
    ready_q.push_back(it);
    item_total++;
  endtask

  // Mostly short ranges near a drifting hot spot so runs merge; some noise
  function automatic ready_item_t random_item();
    ready_item_t it;
    int          roll;
    int          len;
    int          f;
    int          l;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) hot_base = $urandom_range(0, MAX_PARTITIONS - 1);
    f = hot_base + $urandom_range(0, 47);
    if (f > MAX_PARTITIONS - 1) f = MAX_PARTITIONS - 1;
    if (roll < 70)      len = $urandom_range(1, 4);
    else if (roll < 92) len = $urandom_range(1, 32);
    else                len = $urandom_range(1, MAX_PARTITIONS);
    l = f + len - 1;
    if (l > MAX_PARTITIONS - 1) l = MAX_PARTITIONS - 1;
    it.opcode = OP_MARK;
    it.first  = part_t'(f);
    it.last   = part_t'(l);
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      it.opcode = OP_CLEAR;
      it.first  = part_t'($urandom);
      it.last   = part_t'($urandom);
    end else if (roll < 7) begin
      // reversed range, ignored by the block
      it.first = part_t'($urandom_range(1, MAX_PARTITIONS - 1));
      it.last  = part_t'($urandom_range(0, int'(it.first) - 1));
    end else if (roll < 8) begin
      it.first = '0;
      it.last  = part_t'(MAX_PARTITIONS - 1);
    end
    return it;
  endfunction

  task automatic write_threshold(thr_t v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rel_threshold = v;
  endtask

  // Wait until every queued item is taken and every result has come back
  task automatic wait_drained();
    while (accepted_cnt != item_total || expected_release_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_release_q.push_back(predict_release(cur_item));
        accepted_cnt++;
      end
      if (!(start && busy)) begin
        if (ready_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = ready_q.pop_front();
          in_opcode      <= cur_item.opcode;
          in_range_first <= cur_item.first;
          in_range_last  <= cur_item.last;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is checked against the oldest prediction
  always @(posedge clk) begin : result_check
    release_t want;
    if (rst_n && out_valid) begin
      if (expected_release_q.size() == 0) begin
        note_error($sformatf("unexpected result released=%0b first=%0d last=%0d",
                             out_released, out_release_first, out_release_last));
      end else begin
        want = expected_release_q.pop_front();
        if (out_released !== want.released || out_release_first !== want.first ||
            out_release_last !== want.last)
          note_error($sformatf({"result mismatch: expected released=%0b first=%0d last=%0d,",
                                " got released=%0b first=%0d last=%0d"},
                               want.released, want.first, want.last,
                               out_released, out_release_first, out_release_last));
      end
    end
  end

  // Stimulus and phase control
  initial begin
    thr_t phase_thr[8];
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: merging, word crossings, repeats, reversed range, clear
    write_threshold(thr_t'(4));
    push_item(OP_MARK, 0, 0);
    push_item(OP_MARK, 2, 2);
    push_item(OP_MARK, 1, 1);
    push_item(OP_MARK, 3, 3);
    push_item(OP_MARK, 1023, 1023);
    push_item(OP_MARK, 1020, 1022);
    push_item(OP_MARK, 10, 11);
    push_item(OP_MARK, 10, 11);
    push_item(OP_MARK, 5, 4);
    push_item(OP_MARK, 1023, 0);
    push_item(OP_CLEAR, 1023, 0);
    push_item(OP_MARK, 12, 12);
    push_item(OP_MARK, 0, 1023);
    push_item(OP_MARK, 63, 63);
    push_item(OP_MARK, 64, 64);
    push_item(OP_MARK, 62, 62);
    push_item(OP_MARK, 65, 65);
    push_item(OP_MARK, 60, 130);
    wait_drained();
    // threshold zero releases every run
    write_threshold(thr_t'(0));
    push_item(OP_MARK, 7, 7);
    push_item(OP_MARK, 1000, 1001);
    wait_drained();
    // threshold beyond capacity never releases
    write_threshold(thr_t'(2047));
    push_item(OP_MARK, 0, 1023);
    push_item(OP_MARK, 5, 9);
    push_item(OP_CLEAR, 0, 0);
    wait_drained();

    // Random phases, idle pattern rotating: none, heavy, light
    phase_thr = '{thr_t'(1), thr_t'(3), thr_t'($urandom_range(2, 40)), thr_t'(64),
                  thr_t'(1024), thr_t'(0), thr_t'(2047), thr_t'(8)};
    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(phase_thr[ph]);
      case (ph % 3)
        0: send_idle_pct = 0;
        1: send_idle_pct = 64;
        default: send_idle_pct = 20;
      endcase
      for (int i = 0; i < 232; i++) begin
        ready_q.push_back(random_item());
        item_total++;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_release_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
